### src/b64sc_pkg.sv
`timescale 1ns / 1ps

package b64sc_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CfgDirection = 2'd0;
  localparam logic [1:0] CfgAlphabet  = 2'd1;

  // The pad character.
  localparam logic [7:0] PadChar = 8'h3D;

  // What the back end does with a finished group.
  typedef enum logic [1:0] {
    JobEncode,
    JobDecode,
    JobBadLen
  } job_kind_e;

  // One finished group, handed from the front end to the back end.
  typedef struct packed {
    logic [23:0] group;  // collected bytes or sextets, first item highest
    job_kind_e   kind;
    logic [2:0]  nres;   // number of results to emit, 1 to 4
    logic [2:0]  keep;   // encode: characters before the pad characters
    logic        last;   // group closes the message
  } job_t;

  // Map a sextet to its alphabet character.
  function automatic logic [7:0] sextet_to_char(logic [5:0] s, logic url);
    logic [7:0] c;
    c = '0;
    if (s < 6'd26) begin
      c = 8'h41 + {2'b00, s};
    end else if (s < 6'd52) begin
      c = 8'h61 + {2'b00, s} - 8'd26;
    end else if (s < 6'd62) begin
      c = 8'h30 + {2'b00, s} - 8'd52;
    end else if (s == 6'd62) begin
      c = url ? 8'h2D : 8'h2B;
    end else begin
      c = url ? 8'h5F : 8'h2F;
    end
    return c;
  endfunction

  // Map a character to its sextet; anything outside the alphabet gives zero.
  function automatic logic [5:0] char_to_sextet(logic [7:0] c, logic url);
    logic [5:0] s;
    s = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      s = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s = 6'(c - 8'h30 + 8'd52);
    end else if (url && c == 8'h2D) begin
      s = 6'd62;
    end else if (url && c == 8'h5F) begin
      s = 6'd63;
    end else if (!url && c == 8'h2B) begin
      s = 6'd62;
    end else if (!url && c == 8'h2F) begin
      s = 6'd63;
    end
    return s;
  endfunction

endpackage

### src/b64sc_front.sv
`timescale 1ns / 1ps

module b64sc_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_index_i,
  input  logic             cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       data_in_i,
  input  logic             is_last_i,
  input  logic             full_i,
  output logic             push_o,
  output b64sc_pkg::job_t  job_o,
  output logic             alphabet_o
);
  import b64sc_pkg::*;

  logic        dir_q;
  logic        alpha_q;
  logic [23:0] gb_q, gb_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        tp_q, tp_d;

  logic        accept;
  logic        is_pad;
  logic [5:0]  sextet;
  logic [1:0]  enc_n;
  logic [23:0] enc_bits;
  logic [23:0] dec_bits;

  // The front end holds off a request while the queue has no room.
  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign alphabet_o = alpha_q;

  assign is_pad = (data_in_i == PadChar);
  assign sextet = is_pad ? 6'd0 : char_to_sextet(data_in_i, alpha_q);
  assign enc_n  = (cnt_q == 2'd3) ? 2'd2 : cnt_q;

  // Place the new byte or sextet into the group, first item highest.
  always_comb begin
    case (enc_n)
      2'd0:    enc_bits = gb_q | {data_in_i, 16'b0};
      2'd1:    enc_bits = gb_q | {8'b0, data_in_i, 8'b0};
      default: enc_bits = gb_q | {16'b0, data_in_i};
    endcase
    case (cnt_q)
      2'd0:    dec_bits = gb_q | {sextet, 18'b0};
      2'd1:    dec_bits = gb_q | {6'b0, sextet, 12'b0};
      2'd2:    dec_bits = gb_q | {12'b0, sextet, 6'b0};
      default: dec_bits = gb_q | {18'b0, sextet};
    endcase
  end

  // Collect items and hand a finished group to the queue.
  always_comb begin
    gb_d   = gb_q;
    cnt_d  = cnt_q;
    tp_d   = tp_q;
    push_o = 1'b0;
    job_o  = '{group: '0, kind: JobEncode, nres: 3'd1, keep: 3'd0, last: 1'b0};
    if (cfg_we_i && cfg_index_i == CfgDirection) begin
      gb_d  = '0;
      cnt_d = '0;
      tp_d  = 1'b0;
    end else if (accept) begin
      if (!dir_q) begin
        if (enc_n != 2'd2 && !is_last_i) begin
          gb_d  = enc_bits;
          cnt_d = enc_n + 2'd1;
        end else begin
          push_o     = 1'b1;
          job_o.group = enc_bits;
          job_o.kind  = JobEncode;
          job_o.nres  = 3'd4;
          job_o.keep  = {1'b0, enc_n} + 3'd2;
          job_o.last  = is_last_i;
          gb_d  = '0;
          cnt_d = '0;
          tp_d  = 1'b0;
        end
      end else begin
        if (cnt_q == 2'd3) begin
          // A full quad; the final one drops a byte for each trailing pad.
          push_o      = 1'b1;
          job_o.group = dec_bits;
          job_o.kind  = JobDecode;
          job_o.nres  = 3'd3 - {2'b00, is_last_i & is_pad} - {2'b00, is_last_i & tp_q};
          job_o.last  = is_last_i;
          gb_d  = '0;
          cnt_d = '0;
          tp_d  = 1'b0;
        end else if (is_last_i) begin
          // The message ends inside a quad.
          push_o     = 1'b1;
          job_o.kind = JobBadLen;
          job_o.nres = 3'd1;
          job_o.last = 1'b1;
          gb_d  = '0;
          cnt_d = '0;
          tp_d  = 1'b0;
        end else begin
          gb_d  = dec_bits;
          cnt_d = cnt_q + 2'd1;
          if (cnt_q == 2'd2) begin
            tp_d = is_pad;
          end
        end
      end
    end
  end

  // Configuration and group state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q   <= 1'b0;
      alpha_q <= 1'b0;
      gb_q    <= '0;
      cnt_q   <= '0;
      tp_q    <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_index_i == CfgDirection) begin
        dir_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_index_i == CfgAlphabet) begin
        alpha_q <= cfg_data_i;
      end
      gb_q  <= gb_d;
      cnt_q <= cnt_d;
      tp_q  <= tp_d;
    end
  end

  // Encoding never collects more than two bytes before a group closes.
  a_enc_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !dir_q |-> cnt_q != 2'd3)
    else $error("encode group count out of range");

endmodule

### src/b64sc_queue.sv
`timescale 1ns / 1ps

module b64sc_queue #(
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  b64sc_pkg::job_t  job_i,
  output logic             full_o,
  input  logic             pop_i,
  output b64sc_pkg::job_t  job_o,
  output logic             empty_o
);
  import b64sc_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign job_o   = mem_q[rd_ptr_q];

  // Group storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("group queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("group queue read while empty");

endmodule

### src/b64sc_back.sv
`timescale 1ns / 1ps

module b64sc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             alphabet_i,
  input  b64sc_pkg::job_t  job_i,
  input  logic             empty_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       data_out_o,
  output logic             out_last_o,
  output logic             bad_length_o
);
  import b64sc_pkg::*;

  logic [1:0] idx_q;
  logic       valid_q;
  logic [7:0] data_q;
  logic       last_q;
  logic       bad_q;

  logic       advance;
  logic       final_res;
  logic [5:0] sext;
  logic [7:0] byte_sel;
  logic [7:0] data_d;
  logic       bad_d;

  // The output register takes a new result when empty or when taken.
  assign advance   = !valid_q || !out_stall_i;
  assign final_res = ({1'b0, idx_q} == job_i.nres - 3'd1);
  assign pop_o     = advance && !empty_i && final_res;

  // Pick the current result of the head group.
  always_comb begin
    case (idx_q)
      2'd0:    sext = job_i.group[23:18];
      2'd1:    sext = job_i.group[17:12];
      2'd2:    sext = job_i.group[11:6];
      default: sext = job_i.group[5:0];
    endcase
    case (idx_q)
      2'd0:    byte_sel = job_i.group[23:16];
      2'd1:    byte_sel = job_i.group[15:8];
      default: byte_sel = job_i.group[7:0];
    endcase
    bad_d = 1'b0;
    case (job_i.kind)
      JobEncode: begin
        data_d = ({1'b0, idx_q} < job_i.keep) ? sextet_to_char(sext, alphabet_i) : PadChar;
      end
      JobDecode: begin
        data_d = byte_sel;
      end
      default: begin
        data_d = '0;
        bad_d  = 1'b1;
      end
    endcase
  end

  // Result index and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
      data_q  <= '0;
      last_q  <= 1'b0;
      bad_q   <= 1'b0;
    end else if (advance) begin
      valid_q <= !empty_i;
      if (!empty_i) begin
        data_q <= data_d;
        last_q <= job_i.last && final_res;
        bad_q  <= bad_d;
        idx_q  <= final_res ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  assign out_valid_o  = valid_q;
  assign data_out_o   = data_q;
  assign out_last_o   = last_q;
  assign bad_length_o = bad_q;

  a_bad_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && bad_q |-> last_q)
    else $error("bad length result not marked last");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> {1'b0, idx_q} < job_i.nres)
    else $error("result index beyond group size");

endmodule

### src/base64_stream_codec.sv
`timescale 1ns / 1ps

// Streaming Base64 codec, standard or URL-safe alphabet.
// Input channel: in_valid_i / in_stall_o with data_in_i and is_last_i; a
// request moves at a clock edge with valid high and stall low. Output
// channel: out_valid_o / out_stall_i with data_out_o, out_last_o and
// bad_length_o. Configuration: cfg_we_i writes cfg_data_i to register
// cfg_index_i (0 direction, 1 alphabet); write only while idle.
// Encoding takes bytes and gives four characters per three bytes, padded
// on the last byte; decoding takes characters and gives up to three bytes
// per quad. The front end collects a group and pushes it into a small queue;
// the back end emits one result per cycle from the queue head while the
// receiver does not stall. With an empty queue, a group's first result is
// registered after the group is written into the queue. Throughput is set
// by the one-result-per-cycle output register: encode gives four
// characters per three bytes, decode one character per cycle. Input is
// taken every cycle while the queue has room.
// Reset clears the group state, the queue and both configuration registers.
// When the receiver stalls, the current result holds, the queue fills, and
// then in_stall_o rises.
module base64_stream_codec #(
  parameter int QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic       cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_in_i,
  input  logic       is_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] data_out_o,
  output logic       out_last_o,
  output logic       bad_length_o
);
  import b64sc_pkg::*;

  logic push;
  logic full;
  logic pop;
  logic empty;
  logic alphabet;
  job_t job_in;
  job_t job_head;

  b64sc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_in_i   (data_in_i),
    .is_last_i   (is_last_i),
    .full_i      (full),
    .push_o      (push),
    .job_o       (job_in),
    .alphabet_o  (alphabet)
  );

  b64sc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .job_o   (job_head),
    .empty_o (empty)
  );

  b64sc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .alphabet_i   (alphabet),
    .job_i        (job_head),
    .empty_i      (empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .data_out_o   (data_out_o),
    .out_last_o   (out_last_o),
    .bad_length_o (bad_length_o)
  );

endmodule
